// ===== sv/fsge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_pkg
// Shared types and constants of the frame-sum gain estimator.
// ----------------------------------------------------------------------------
package fsge_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 16;
  localparam int SAMPLE_W  = 16;
  localparam int PC_W      = 17;
  localparam int SUM_W     = 40;
  localparam int TOTAL_W   = 64;
  localparam int FRAME_W   = 32;
  localparam int GAIN_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int DEN_W     = 64;
  localparam int NUM_W     = TOTAL_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int REG_IDX_W = 1;

  localparam logic [PC_W-1:0]    PIXEL_COUNT_RST = 17'h10000;
  localparam logic [SUM_W-1:0]   GAIN_ONE        = 40'h00_0001_0000;
  localparam logic [GAIN_W-1:0]  GAIN_MAX        = 32'hFFFF_FFFF;
  localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};
  localparam logic [FRAME_W-1:0] FRAME_MAX       = {FRAME_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PIXEL_COUNT = 1'b0,
    REG_INVERT_MODE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_RD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;     // item taken, latch payload and launch memory read
    logic clr_start;  // clear op: zero scalars, restart sweep address
    logic clr_step;   // write one zero entry of the sum store
    logic acc;        // read-modify-write of one pixel sum
    logic rd_latch;   // capture pixel sum for a read
    logic mul_lo;     // low partial product, load divider
    logic mul_hi;     // high partial product
    logic div_step;   // one restoring division step
    logic out_load;   // load output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;   // sweep at last entry
    logic need_div;   // gain path with nonzero sum
    logic div_last;   // final division step
    logic out_busy;   // output register full and stalled
  } sts_t;

endpackage

// ===== sv/fsge_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_if
// Valid/ready channels of the frame-sum gain estimator.
// ----------------------------------------------------------------------------
interface fsge_item_if;
  logic                           valid;
  logic                           ready;
  logic [fsge_pkg::OP_W-1:0]      operation;
  logic [fsge_pkg::IDX_W-1:0]     pixel_index;
  logic [fsge_pkg::SAMPLE_W-1:0]  sample;
  logic                           frame_last;

  modport source (output valid, operation, pixel_index, sample, frame_last, input ready);
  modport sink   (input valid, operation, pixel_index, sample, frame_last, output ready);
endinterface

interface fsge_result_if;
  logic                           valid;
  logic                           ready;
  logic [fsge_pkg::SUM_W-1:0]     result_value;
  logic [fsge_pkg::FRAME_W-1:0]   frames_used;
  logic                           saturated;

  modport source (output valid, result_value, frames_used, saturated, input ready);
  modport sink   (input valid, result_value, frames_used, saturated, output ready);
endinterface

interface fsge_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fsge_pkg::REG_IDX_W-1:0] reg_index;
  logic [fsge_pkg::PC_W-1:0]      reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ===== sv/frame_sum_gain_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sum_gain_estimator_top
// Per-pixel frame sum store with flat-field gain readout.
// ----------------------------------------------------------------------------
// Accumulates detector frames into a PIXELS-entry store of saturating 40-bit
// sums, plus a saturating 64-bit total and a 32-bit frame counter. One input
// transaction is handled at a time. Accumulate reads the store entry, then
// writes it back. A read with invert_mode = 0 or a zero sum latches the sum
// and loads the result register; a gain read also runs the 80-step restoring
// divider that forms Q16.16 total / (pixel_count * sum), one quotient bit per
// cycle. A clear runs the sweep that zeroes one store entry per cycle. After
// reset the same sweep runs over all PIXELS entries (65536 by default) with
// item_in.ready low. The result register lets the next transaction enter
// while a result waits on result_out. Config writes are always accepted and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module frame_sum_gain_estimator_top #(
  parameter int PIXELS      = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  fsge_item_if.sink     item_in,
  fsge_result_if.source result_out,
  fsge_cfg_if.sink      cfg
);
  import fsge_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config writes are always accepted and registered
  assign cfg.ready = 1'b1;

  // sequencer: decides what the datapath does each cycle
  fsge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_op    (item_in.operation),
    .in_ready (item_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, counters, multiplier, divider and result register
  fsge_dp #(
    .PIXELS      (PIXELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_index   (item_in.pixel_index),
    .in_sample  (item_in.sample),
    .in_last    (item_in.frame_last),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.reg_index),
    .cfg_data   (cfg.reg_data),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_value  (result_out.result_value),
    .out_frames (result_out.frames_used),
    .out_sat    (result_out.saturated)
  );

endmodule

// ===== sv/fsge_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_ctrl
// Sequencer: clear sweep, accumulate, read with multiply and divide.
// ----------------------------------------------------------------------------
module fsge_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [fsge_pkg::OP_W-1:0] in_op,
  output logic                      in_ready,
  input  fsge_pkg::sts_t            sts,
  output fsge_pkg::cmd_t            cmd
);
  import fsge_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = (state == ST_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_ACC:   state_next = ST_ACC;
            OP_READ:  state_next = ST_RD;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACC:    state_next = ST_IDLE;
      ST_RD:     state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = sts.need_div ? ST_MUL_HI : ST_DONE;
      ST_MUL_HI: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd           = '0;
    cmd.accept    = accept;
    cmd.clr_start = accept && (in_op == OP_CLEAR);
    cmd.clr_step  = (state == ST_CLEAR);
    cmd.acc       = (state == ST_ACC);
    cmd.rd_latch  = (state == ST_RD);
    cmd.mul_lo    = (state == ST_MUL_LO);
    cmd.mul_hi    = (state == ST_MUL_HI);
    cmd.div_step  = (state == ST_DIV);
    cmd.out_load  = (state == ST_DONE) && !sts.out_busy;
  end

  a_reset_sweep: assert property (@(posedge clk) (!rst && $past(rst)) |-> state == ST_CLEAR)
    else $error("clearing pass does not follow reset");
  a_clear_op: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_start |=> state == ST_CLEAR)
    else $error("clear transaction did not start sweep");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && sts.out_busy) |=> state == ST_DONE)
    else $error("result dropped while output stalled");

endmodule

// ===== sv/fsge_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_dp
// Datapath: sum store, totals, config registers, multiplier, divider, output.
// ----------------------------------------------------------------------------
module fsge_dp #(
  parameter int PIXELS      = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fsge_pkg::cmd_t                 cmd,
  output fsge_pkg::sts_t                 sts,
  input  logic [fsge_pkg::IDX_W-1:0]     in_index,
  input  logic [fsge_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                           in_last,
  input  logic                           cfg_valid,
  input  logic [fsge_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [fsge_pkg::PC_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fsge_pkg::SUM_W-1:0]     out_value,
  output logic [fsge_pkg::FRAME_W-1:0]   out_frames,
  output logic                           out_sat
);
  import fsge_pkg::*;

  localparam int ADDR_W = $clog2(PIXELS);
  localparam int CW     = (ADDR_W + 1 > PC_W) ? ADDR_W + 1 : PC_W;
  localparam int SMP_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [CW-1:0]     PIX_LIM   = CW'(PIXELS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PIXELS - 1);

  // config
  logic [PC_W-1:0] pixel_count;
  logic            invert_mode;

  // scalar state
  logic [TOTAL_W-1:0] total;
  logic [FRAME_W-1:0] frame_cnt;
  logic               overflow_seen;
  logic [ADDR_W-1:0]  clr_addr;

  // item
  logic [IDX_W-1:0]   item_idx;
  logic [SMP_W-1:0]   item_smp;
  logic               item_last;

  // sum store
  logic [SUM_W-1:0]   sum_mem [PIXELS];
  logic [SUM_W-1:0]   rd_data;
  logic [ADDR_W-1:0]  rd_addr, item_addr, wr_addr;
  logic [SUM_W-1:0]   wr_data;
  logic               wr_en;

  // read path
  logic [SUM_W-1:0]     sum_reg;
  logic [DEN_W-1:0]     den;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [CW-1:0]          pc_ext, n_act, idx_ext;
  logic [CW+IDX_W-1:0]    idx_wide;
  logic [ADDR_W+IDX_W-1:0] in_addr_wide, item_addr_wide;
  logic                   in_range;
  logic [SUM_W:0]         sum_inc;
  logic [SUM_W-1:0]       sum_next;
  logic                   sum_ovf;
  logic [TOTAL_W:0]       total_inc;
  logic [CW+31:0]         pp_lo;
  logic [CW+7:0]          pp_hi;
  logic [DEN_W-1:0]       pp_hi_ext;
  logic [DEN_W:0]         rem_sh;
  logic                   rem_ge;
  logic                   sum_zero, gain_sat;
  logic [GAIN_W-1:0]      gain;

  // active pixel count, clamped to [1, PIXELS]
  always_comb begin
    pc_ext = CW'(pixel_count);
    if (pc_ext == '0)          n_act = CW'(1);
    else if (pc_ext > PIX_LIM) n_act = PIX_LIM;
    else                       n_act = pc_ext;
  end

  assign idx_wide       = {{CW{1'b0}}, item_idx};
  assign idx_ext        = idx_wide[CW-1:0];
  assign in_range       = idx_ext < n_act;
  assign in_addr_wide   = {{ADDR_W{1'b0}}, in_index};
  assign item_addr_wide = {{ADDR_W{1'b0}}, item_idx};
  assign rd_addr        = in_addr_wide[ADDR_W-1:0];
  assign item_addr      = item_addr_wide[ADDR_W-1:0];

  assign sum_inc   = {1'b0, rd_data} + {{(SUM_W + 1 - SMP_W){1'b0}}, item_smp};
  assign sum_ovf   = sum_inc[SUM_W];
  assign sum_next  = sum_ovf ? SUM_MAX : sum_inc[SUM_W-1:0];
  assign total_inc = {1'b0, total} + {{(TOTAL_W + 1 - SMP_W){1'b0}}, item_smp};

  assign wr_en   = cmd.clr_step || (cmd.acc && in_range);
  assign wr_addr = cmd.clr_step ? clr_addr : item_addr;
  assign wr_data = cmd.clr_step ? '0 : sum_next;

  always_ff @(posedge clk) begin
    if (wr_en) sum_mem[wr_addr] <= wr_data;
    if (cmd.accept) rd_data <= sum_mem[rd_addr];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= PIXEL_COUNT_RST;
      invert_mode <= 1'b1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PIXEL_COUNT: pixel_count <= cfg_data;
        REG_INVERT_MODE: invert_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // totals, frame counter, sticky flag, sweep address
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      total         <= '0;
      frame_cnt     <= '0;
      overflow_seen <= 1'b0;
      clr_addr      <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + ADDR_W'(1);
      if (cmd.acc) begin
        if (in_range) begin
          if (total_inc[TOTAL_W]) begin
            total         <= TOTAL_MAX;
            overflow_seen <= 1'b1;
          end else begin
            total <= total_inc[TOTAL_W-1:0];
          end
          if (sum_ovf) overflow_seen <= 1'b1;
        end
        if (item_last && frame_cnt != FRAME_MAX) frame_cnt <= frame_cnt + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_idx  <= in_index;
      item_smp  <= in_sample[SMP_W-1:0];
      item_last <= in_last;
    end
  end

  // multiply n * sum in two partial products
  assign pp_lo     = n_act * sum_reg[31:0];
  assign pp_hi     = n_act * sum_reg[SUM_W-1:32];
  assign pp_hi_ext = DEN_W'(pp_hi);

  // restoring division of {total, 16'b0} by den, quotient shifts into num
  assign rem_sh = {rem, num[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.rd_latch) sum_reg <= in_range ? rd_data : '0;
    if (cmd.mul_lo) begin
      den     <= DEN_W'(pp_lo);
      num     <= {total, {FRAC_W{1'b0}}};
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.mul_hi) den <= den + {pp_hi_ext[DEN_W-33:0], 32'd0};
    if (cmd.div_step) begin
      rem     <= rem_ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      num     <= {num[NUM_W-2:0], rem_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign sum_zero = (sum_reg == '0);
  assign gain_sat = |num[NUM_W-1:GAIN_W];
  assign gain     = gain_sat ? GAIN_MAX : num[GAIN_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_frames <= frame_cnt;
      if (invert_mode) begin
        out_value <= sum_zero ? GAIN_ONE : {{(SUM_W - GAIN_W){1'b0}}, gain};
        out_sat   <= overflow_seen || (!sum_zero && gain_sat);
      end else begin
        out_value <= sum_reg;
        out_sat   <= overflow_seen;
      end
    end
  end

  always_comb begin
    sts          = '0;
    sts.clr_last = (clr_addr == ADDR_LAST);
    sts.need_div = invert_mode && !sum_zero;
    sts.div_last = (div_cnt == DIV_CNT_W'(NUM_W - 1));
    sts.out_busy = out_valid && !out_ready;
  end

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.clr_start)) |-> total >= $past(total))
    else $error("total count decreased without clear");
  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.clr_start)) |->
      (frame_cnt == $past(frame_cnt) || frame_cnt == $past(frame_cnt) + FRAME_W'(1)))
    else $error("frame counter jumped");
  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    (overflow_seen && !cmd.clr_start) |=> overflow_seen)
    else $error("saturation flag lost without clear");
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.acc && cmd.clr_step))
    else $error("accumulate and sweep write in same cycle");

endmodule
